/* design/gpm_pkg.sv */
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types and constants of the gamepad I/O port mux.
// ----------------------------------------------------------------------------
package gpm_pkg;

    localparam int unsigned NUM_REGS  = 16;
    localparam int unsigned NUM_PORTS = 2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_READ    = 2'd0;
    localparam mode_t MODE_WRITE   = 2'd1;
    localparam mode_t MODE_TIMEOUT = 2'd2;

    typedef logic [3:0] reg_idx_t;
    localparam reg_idx_t REG_VERSION = 4'd0;
    localparam reg_idx_t REG_DATA1   = 4'd1;
    localparam reg_idx_t REG_DATA2   = 4'd2;
    localparam reg_idx_t REG_CTRL1   = 4'd4;
    localparam reg_idx_t REG_CTRL2   = 4'd5;

    typedef logic cfg_idx_t;
    localparam cfg_idx_t CFG_SIX_BUTTON = 1'b0;
    localparam cfg_idx_t CFG_VERSION    = 1'b1;

    typedef logic [2:0] phase_t;
    localparam phase_t PHASE_MAX = 3'd4;
    localparam phase_t PHASE_TWO = 3'd2;
    localparam phase_t PHASE_THR = 3'd3;

    localparam int unsigned TH_BIT = 6;
    localparam logic [7:0] MASK_MSB = 8'h80;

    typedef struct packed {
        mode_t       mode;
        reg_idx_t    reg_index;
        logic [7:0]  write_data;
        logic [11:0] pad1_buttons;
        logic [11:0] pad2_buttons;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
    } out_item_t;

    // per-port view of the register file, for the pad mux
    typedef struct packed {
        logic        six_en;
        phase_t      phase;
        logic [7:0]  data;
        logic [7:0]  ctrl;
    } pad_ctl_t;

    typedef struct packed {
        logic [7:0]  rd_byte;
        pad_ctl_t    port1;
        pad_ctl_t    port2;
    } rf_view_t;

endpackage

/* design/gpm_stream_if.sv */
// ----------------------------------------------------------------------------
// gpm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface gpm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/gamepad_io_port_mux.sv */
// ----------------------------------------------------------------------------
// gamepad_io_port_mux
// Two-port gamepad I/O register block with six-button TH multiplexing.
// ----------------------------------------------------------------------------
// Takes one access per clock: a read, a write or a phase timeout. The block
// captures an access in an input register at its transfer. In the following
// cycle it evaluates the access against the register file. When the access
// leaves the input register, a write or timeout updates state and a read
// loads the result register, so a read's result passes through the input
// register and then the result register before rsp.valid rises. Throughput
// is one access per cycle. Only a read waiting behind a full result register
// that the consumer is stalling holds off the input. Writes and timeouts
// produce no result.
module gamepad_io_port_mux
    import gpm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  cfg_idx_t       cfg_index,
    input  logic [7:0]     cfg_data,
    gpm_stream_if.sink     req,
    gpm_stream_if.source   rsp
);

    logic       six_en_reg;
    logic [7:0] version_reg;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_item_t   s1_item_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;

    logic       s1_is_read;
    logic       s1_fire;
    rf_view_t   view;
    logic [7:0] pad1_byte;
    logic [7:0] pad2_byte;
    logic [7:0] rd_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            six_en_reg  <= 1'b0;
            version_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIX_BUTTON: six_en_reg  <= cfg_data[0];
                CFG_VERSION:    version_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign s1_is_read    = (s1_item_reg.mode == MODE_READ);
    assign s1_fire       = s1_valid_reg && (!s1_is_read || !out_valid_reg || rsp.ready);
    assign req.ready     = !s1_valid_reg || s1_fire;
    assign s1_valid_next = req.valid ? 1'b1 : (s1_valid_reg && !s1_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= req.data;
        end
    end

    gpm_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_fire    (s1_fire),
        .mode       (s1_item_reg.mode),
        .reg_index  (s1_item_reg.reg_index),
        .write_data (s1_item_reg.write_data),
        .six_en     (six_en_reg),
        .view       (view)
    );

    gpm_pad_mux u_pad1 (
        .ctl      (view.port1),
        .buttons  (s1_item_reg.pad1_buttons),
        .pad_byte (pad1_byte)
    );

    gpm_pad_mux u_pad2 (
        .ctl      (view.port2),
        .buttons  (s1_item_reg.pad2_buttons),
        .pad_byte (pad2_byte)
    );

    always_comb
    begin
        unique case (s1_item_reg.reg_index)
            REG_VERSION: rd_byte = version_reg;
            REG_DATA1:   rd_byte = pad1_byte;
            REG_DATA2:   rd_byte = pad2_byte;
            default:     rd_byte = view.rd_byte;
        endcase
    end

    assign out_valid_next = (s1_fire && s1_is_read) ? 1'b1 : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_read)
        begin
            out_item_reg.read_data <= {rd_byte, rd_byte};
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> s1_valid_reg && s1_is_read && out_valid_reg && !rsp.ready)
        else $error("input stalled without a blocked read");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_is_read) |=> rsp.valid)
        else $error("read lost before result register");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_is_read && (!out_valid_reg || rsp.ready)) |=> !rsp.valid)
        else $error("result without a read");
`endif

endmodule

/* design/gpm_pad_mux.sv */
// ----------------------------------------------------------------------------
// gpm_pad_mux
// Selects the pad bits of one port by TH and phase, then merges outputs.
// ----------------------------------------------------------------------------
module gpm_pad_mux
    import gpm_pkg::*;
(
    input  pad_ctl_t    ctl,
    input  logic [11:0] buttons,
    output logic [7:0]  pad_byte
);

    logic [11:0] pad;
    logic        th;
    logic [7:0]  sel;

    assign pad = ~buttons;
    assign th  = ctl.data[TH_BIT];

    always_comb
    begin
        priority if (ctl.six_en && ctl.phase == PHASE_TWO && !th)
        begin
            sel = {2'b00, pad[7:6], 4'b0000};
        end
        else if (ctl.six_en && ctl.phase == PHASE_THR && th)
        begin
            sel = {2'b00, pad[5:4], pad[11:8]};
        end
        else if (ctl.six_en && ctl.phase == PHASE_THR && !th)
        begin
            sel = {2'b00, pad[7:6], 4'b1111};
        end
        else if (th)
        begin
            sel = {2'b00, pad[5:0]};
        end
        else
        begin
            sel = {2'b00, pad[7:6], 2'b00, pad[1:0]};
        end
    end

    assign pad_byte = sel | (ctl.data & ctl.ctrl) | (ctl.data & MASK_MSB);

endmodule

/* design/gpm_regfile.sv */
// ----------------------------------------------------------------------------
// gpm_regfile
// Sixteen byte registers and the per-port TH phase counters.
// ----------------------------------------------------------------------------
module gpm_regfile
    import gpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_fire,
    input  mode_t      mode,
    input  reg_idx_t   reg_index,
    input  logic [7:0] write_data,
    input  logic       six_en,
    output rf_view_t   view
);

    logic [7:0] regs_reg  [NUM_REGS];
    phase_t     phase_reg [NUM_PORTS];
    phase_t     phase_next [NUM_PORTS];

    logic wr_fire;
    logic to_fire;

    assign wr_fire = op_fire && (mode == MODE_WRITE);
    assign to_fire = op_fire && (mode == MODE_TIMEOUT);

    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            phase_next[p] = phase_reg[p];
            if (to_fire)
            begin
                phase_next[p] = '0;
            end
            else if (wr_fire && six_en && reg_index == reg_idx_t'(p + 1)
                     && !regs_reg[p + 1][TH_BIT] && write_data[TH_BIT]
                     && phase_reg[p] < PHASE_MAX)
            begin
                phase_next[p] = phase_reg[p] + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                phase_reg[p] <= '0;
            end
        end
        else
        begin
            if (wr_fire)
            begin
                regs_reg[reg_index] <= write_data;
            end
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                phase_reg[p] <= phase_next[p];
            end
        end
    end

    assign view.rd_byte      = regs_reg[reg_index];
    assign view.port1.six_en = six_en;
    assign view.port1.phase  = phase_reg[0];
    assign view.port1.data   = regs_reg[REG_DATA1];
    assign view.port1.ctrl   = regs_reg[REG_CTRL1];
    assign view.port2.six_en = six_en;
    assign view.port2.phase  = phase_reg[1];
    assign view.port2.data   = regs_reg[REG_DATA2];
    assign view.port2.ctrl   = regs_reg[REG_CTRL2];

`ifndef ASSERT_OFF
    a_phase_sat: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg[0] <= PHASE_MAX && phase_reg[1] <= PHASE_MAX)
        else $error("phase counter above saturation");

    a_timeout_clr: assert property (@(posedge clk) disable iff (!rst_n)
        to_fire |=> phase_reg[0] == '0 && phase_reg[1] == '0)
        else $error("timeout did not clear phases");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg[0] != $past(phase_reg[0])
        |-> phase_reg[0] == '0 || phase_reg[0] == $past(phase_reg[0]) + 3'd1)
        else $error("port one phase jumped");
`endif

endmodule
